// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the mapping block rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define APM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define APM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/apm_pkg.sv -----
// shared constants and codes of the parallelogram mapping block
package apm_pkg;

   localparam int APM_FRAC_BITS = 16;
   localparam int APM_WORD_BITS = 32;

   // digit width of one partial product in the multipliers
   localparam int MUL_DIG = 32;

   localparam int MODE_BITS   = 2;
   localparam int FACE_BITS   = 3;
   localparam int STATUS_BITS = 2;

   localparam int APM_FACES_PER_AXIS = 2;

   // operation codes
   localparam logic [MODE_BITS-1:0] MODE_MAP  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_AREA = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FACE = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_GRAD = 2'd3;

   // face axis codes
   localparam logic [FACE_BITS-1:0] AXIS_Y = 3'd0;
   localparam logic [FACE_BITS-1:0] AXIS_X = 3'd1;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FACE  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_DEGEN = 2'd2;

endpackage

// ----- rtl/core/apm_dly.sv -----
// enabled shift register that carries payload alongside the pipeline
module apm_dly import apm_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             adv_i,
   input  logic [WIDTH-1:0] d_i,
   output logic [WIDTH-1:0] q_o
);

   logic [WIDTH-1:0] stage_ff [0:DEPTH-1];

   // shift one place per pipeline advance
   always_ff @(posedge clock) begin
      if (adv_i) begin
         stage_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign q_o = stage_ff[DEPTH-1];

endmodule

// ----- rtl/core/apm_mul.sv -----
// three-stage signed multiplier built from digit partial products
module apm_mul import apm_pkg::*; #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                 clock,
   input  logic                 adv_i,
   input  logic signed [AW-1:0] a_i,
   input  logic signed [BW-1:0] b_i,
   output logic signed [AW+BW-1:0] p_o
);

   localparam int NA = (AW + MUL_DIG - 1) / MUL_DIG;
   localparam int NB = (BW + MUL_DIG - 1) / MUL_DIG;
   localparam int SW = (NA + NB) * MUL_DIG;
   localparam int PW = AW + BW;

   logic [AW-1:0]         abs_a;
   logic [BW-1:0]         abs_b;
   logic [NA*MUL_DIG-1:0] ma;
   logic [NB*MUL_DIG-1:0] mb;
   logic [2*MUL_DIG-1:0]  pp_in [NA][NB];
   logic [2*MUL_DIG-1:0]  pp_ff [NA][NB];
   logic                  neg1_ff;
   logic [SW-1:0]         acc;
   logic [PW-1:0]         mag_ff;
   logic                  neg2_ff;
   logic signed [PW-1:0]  p_in;
   logic signed [PW-1:0]  p_ff;

   // magnitudes split into digits, one partial product per digit pair
   always_comb begin
      abs_a = a_i[AW-1] ? AW'(~a_i + 1'b1) : a_i;
      abs_b = b_i[BW-1] ? BW'(~b_i + 1'b1) : b_i;
      ma = (NA*MUL_DIG)'(abs_a);
      mb = (NB*MUL_DIG)'(abs_b);
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = (2*MUL_DIG)'(ma[i*MUL_DIG +: MUL_DIG])
                        * (2*MUL_DIG)'(mb[j*MUL_DIG +: MUL_DIG]);
         end
      end
   end

   // sum of the shifted partial products
   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (SW'(pp_ff[i][j]) << (MUL_DIG * (i + j)));
         end
      end
   end

   // sign applied last
   assign p_in = neg2_ff ? PW'(~mag_ff + 1'b1) : mag_ff;

   always_ff @(posedge clock) begin
      if (adv_i) begin
         pp_ff   <= pp_in;
         neg1_ff <= a_i[AW-1] ^ b_i[BW-1];
         mag_ff  <= acc[PW-1:0];
         neg2_ff <= neg1_ff;
         p_ff    <= p_in;
      end
   end

   assign p_o = p_ff;

endmodule

// ----- rtl/core/affine_parallelogram_map_2d.sv -----
// throughput: one beat per cycle while rsp is not stalled; depth is set by the divider, one quotient bit per stage
// a stalled rsp side holds the whole pipeline, nothing is dropped or repeated
// reset clears the stage valid bits only; no clearing pass, ready right after reset
module affine_parallelogram_map_2d import apm_pkg::*; #(
   parameter int FRAC_BITS = APM_FRAC_BITS,
   parameter int WORD_BITS = APM_WORD_BITS,
   localparam int REQ_DW = ((10 * WORD_BITS + FACE_BITS + 7) / 8) * 8,
   localparam int RSP_DW = ((2 * WORD_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
   // ref_x, ref_y, vec_0, vec_1, face
   input  logic [REQ_DW-1:0]      req_tdata,
   // mode
   input  logic [MODE_BITS-1:0]   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result_0, result_1
   output logic [RSP_DW-1:0]      rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0] rsp_tuser
);

`include "assert_macros.svh"

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int E   = W + 1;
   localparam int GW  = 2 * W + 3;
   localparam int DW  = 4 * W + 6;
   localparam int AW3 = 3 * W + 3;
   localparam int NW  = 4 * W + 4;
   localparam int SW0 = 2 * W + F + 3;
   localparam int RW  = 5 * W + F + 6;
   localparam int L   = W + 15;

   localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   // ---------------- stage valid bits and flow ----------------
   logic         adv;
   logic [L:1]   vs_ff;
   logic [L:1]   vs_in;

   assign adv        = !vs_ff[L] || rsp_tready;
   assign req_tready = adv;
   assign vs_in      = {vs_ff[L-1:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= '0;
      end else if (adv) begin
         vs_ff <= vs_in;
      end
   end

   // ---------------- stage 1: capture and edge vectors ----------------
   logic signed [W-1:0] c0x, c0y, c1x, c1y, c2x, c2y;
   logic signed [E-1:0] ex_x_in, ex_y_in, ey_x_in, ey_y_in;
   logic signed [E-1:0] ex_x_ff, ex_y_ff, ey_x_ff, ey_y_ff;
   logic signed [W-1:0] c0x_ff, c0y_ff, rx_ff, ry_ff, t0_ff, t1_ff;
   logic [MODE_BITS-1:0] mode_ff;
   logic [FACE_BITS-1:0] face_ff;

   assign c0x = req_tdata[0*W +: W];
   assign c0y = req_tdata[1*W +: W];
   assign c1x = req_tdata[2*W +: W];
   assign c1y = req_tdata[3*W +: W];
   assign c2x = req_tdata[4*W +: W];
   assign c2y = req_tdata[5*W +: W];

   assign ex_x_in = {c1x[W-1], c1x} - {c0x[W-1], c0x};
   assign ex_y_in = {c1y[W-1], c1y} - {c0y[W-1], c0y};
   assign ey_x_in = {c2x[W-1], c2x} - {c0x[W-1], c0x};
   assign ey_y_in = {c2y[W-1], c2y} - {c0y[W-1], c0y};

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_x_ff <= ex_x_in;
         ex_y_ff <= ex_y_in;
         ey_x_ff <= ey_x_in;
         ey_y_ff <= ey_y_in;
         c0x_ff  <= c0x;
         c0y_ff  <= c0y;
         rx_ff   <= req_tdata[6*W +: W];
         ry_ff   <= req_tdata[7*W +: W];
         t0_ff   <= req_tdata[8*W +: W];
         t1_ff   <= req_tdata[9*W +: W];
         face_ff <= req_tdata[10*W +: FACE_BITS];
         mode_ff <= req_tuser;
      end
   end

   // ---------------- stages 2-4: edge products ----------------
   logic signed [2*E-1:0]   p_xx, p_xy_sq, p_yx, p_yy, p_g12a, p_g12b;
   logic signed [W+E-1:0]   p_rxx, p_ryx, p_rxy, p_ryy;

   apm_mul #(.AW(E), .BW(E)) u_m_xx  (.clock, .adv_i(adv), .a_i(ex_x_ff), .b_i(ex_x_ff), .p_o(p_xx));
   apm_mul #(.AW(E), .BW(E)) u_m_xy  (.clock, .adv_i(adv), .a_i(ex_y_ff), .b_i(ex_y_ff), .p_o(p_xy_sq));
   apm_mul #(.AW(E), .BW(E)) u_m_yx  (.clock, .adv_i(adv), .a_i(ey_x_ff), .b_i(ey_x_ff), .p_o(p_yx));
   apm_mul #(.AW(E), .BW(E)) u_m_yy  (.clock, .adv_i(adv), .a_i(ey_y_ff), .b_i(ey_y_ff), .p_o(p_yy));
   apm_mul #(.AW(E), .BW(E)) u_m_ga  (.clock, .adv_i(adv), .a_i(ex_x_ff), .b_i(ey_x_ff), .p_o(p_g12a));
   apm_mul #(.AW(E), .BW(E)) u_m_gb  (.clock, .adv_i(adv), .a_i(ex_y_ff), .b_i(ey_y_ff), .p_o(p_g12b));
   apm_mul #(.AW(W), .BW(E)) u_m_rxx (.clock, .adv_i(adv), .a_i(rx_ff), .b_i(ex_x_ff), .p_o(p_rxx));
   apm_mul #(.AW(W), .BW(E)) u_m_ryx (.clock, .adv_i(adv), .a_i(ry_ff), .b_i(ey_x_ff), .p_o(p_ryx));
   apm_mul #(.AW(W), .BW(E)) u_m_rxy (.clock, .adv_i(adv), .a_i(rx_ff), .b_i(ex_y_ff), .p_o(p_rxy));
   apm_mul #(.AW(W), .BW(E)) u_m_ryy (.clock, .adv_i(adv), .a_i(ry_ff), .b_i(ey_y_ff), .p_o(p_ryy));

   logic [2*W-1:0] c0_s4;
   logic [2*W-1:0] t_s5;

   apm_dly #(.WIDTH(2*W), .DEPTH(3)) u_d_c0 (.clock, .adv_i(adv), .d_i({c0y_ff, c0x_ff}), .q_o(c0_s4));
   apm_dly #(.WIDTH(2*W), .DEPTH(4)) u_d_t  (.clock, .adv_i(adv), .d_i({t1_ff, t0_ff}),   .q_o(t_s5));

   // ---------------- stage 5: gram entries, point sums ----------------
   logic signed [W-1:0]   c0x_s4, c0y_s4;
   logic signed [GW-1:0]  g11_ff, g12_ff, g22_ff;
   logic signed [SW0-1:0] sx_ff, sy_ff, sx_in, sy_in;

   assign c0x_s4 = c0_s4[W-1:0];
   assign c0y_s4 = c0_s4[2*W-1:W];

   assign sx_in = (SW0'(c0x_s4) <<< F) + SW0'(p_rxx) + SW0'(p_ryx) + (SW0'(1) << (F - 1));
   assign sy_in = (SW0'(c0y_s4) <<< F) + SW0'(p_rxy) + SW0'(p_ryy) + (SW0'(1) << (F - 1));

   always_ff @(posedge clock) begin
      if (adv) begin
         g11_ff <= GW'(p_xx) + GW'(p_xy_sq);
         g12_ff <= GW'(p_g12a) + GW'(p_g12b);
         g22_ff <= GW'(p_yx) + GW'(p_yy);
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
      end
   end

   // ---------------- stage 6: point rounding and saturation ----------------
   function automatic logic [W-1:0] round_sat(logic signed [SW0-1:0] s);
      logic [SW0-W-F:0] hi;
      hi = s[SW0-1:W-1+F];
      if (&hi || ~|hi) begin
         return s[W-1+F:F];
      end else begin
         return s[SW0-1] ? WMIN : WMAX;
      end
   endfunction

   logic [W-1:0]   m0x_ff, m0y_ff;
   logic [2*W-1:0] m0_o;

   always_ff @(posedge clock) begin
      if (adv) begin
         m0x_ff <= round_sat(sx_ff);
         m0y_ff <= round_sat(sy_ff);
      end
   end

   apm_dly #(.WIDTH(2*W), .DEPTH(W+8)) u_d_m0 (.clock, .adv_i(adv), .d_i({m0y_ff, m0x_ff}), .q_o(m0_o));

   // ---------------- stages 6-8: gram products ----------------
   logic signed [W-1:0]   t0_s5, t1_s5;
   logic signed [DW-1:0]  p_gg, p_g12sq;
   logic signed [AW3-1:0] p_a0, p_a1, p_b0, p_b1;

   assign t0_s5 = t_s5[W-1:0];
   assign t1_s5 = t_s5[2*W-1:W];

   apm_mul #(.AW(GW), .BW(GW)) u_m_gg  (.clock, .adv_i(adv), .a_i(g11_ff), .b_i(g22_ff), .p_o(p_gg));
   apm_mul #(.AW(GW), .BW(GW)) u_m_g12 (.clock, .adv_i(adv), .a_i(g12_ff), .b_i(g12_ff), .p_o(p_g12sq));
   apm_mul #(.AW(GW), .BW(W))  u_m_a0  (.clock, .adv_i(adv), .a_i(g22_ff), .b_i(t0_s5), .p_o(p_a0));
   apm_mul #(.AW(GW), .BW(W))  u_m_a1  (.clock, .adv_i(adv), .a_i(g12_ff), .b_i(t1_s5), .p_o(p_a1));
   apm_mul #(.AW(GW), .BW(W))  u_m_b0  (.clock, .adv_i(adv), .a_i(g11_ff), .b_i(t1_s5), .p_o(p_b0));
   apm_mul #(.AW(GW), .BW(W))  u_m_b1  (.clock, .adv_i(adv), .a_i(g12_ff), .b_i(t0_s5), .p_o(p_b1));

   logic [2*GW-1:0] g_s9;
   logic [4*E-1:0]  e_s9;
   logic [MODE_BITS+FACE_BITS-1:0] mf_s9, mf_o;

   apm_dly #(.WIDTH(2*GW), .DEPTH(4)) u_d_g (.clock, .adv_i(adv), .d_i({g22_ff, g11_ff}), .q_o(g_s9));
   apm_dly #(.WIDTH(4*E), .DEPTH(8)) u_d_e (.clock, .adv_i(adv),
      .d_i({ey_y_ff, ey_x_ff, ex_y_ff, ex_x_ff}), .q_o(e_s9));
   apm_dly #(.WIDTH(MODE_BITS+FACE_BITS), .DEPTH(8)) u_d_mf9 (.clock, .adv_i(adv),
      .d_i({face_ff, mode_ff}), .q_o(mf_s9));
   apm_dly #(.WIDTH(MODE_BITS+FACE_BITS), .DEPTH(W+13)) u_d_mfo (.clock, .adv_i(adv),
      .d_i({face_ff, mode_ff}), .q_o(mf_o));

   // ---------------- stage 9: determinant and inverse-gram terms ----------------
   logic signed [DW-1:0]  det_ff;
   logic signed [AW3-1:0] a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= p_gg - p_g12sq;
         a_ff   <= p_a0 - p_a1;
         b_ff   <= p_b0 - p_b1;
      end
   end

   // ---------------- stage 10: square root operand select ----------------
   logic [MODE_BITS-1:0] mode_s9;
   logic [FACE_BITS-1:0] face_s9, axis_s9;
   logic signed [GW-1:0] g11_s9, g22_s9;
   logic [DW-1:0]        xsel;
   logic                 sqsat_ff, detz_ff;
   logic [1:0]           sqf_o;

   assign mode_s9 = mf_s9[MODE_BITS-1:0];
   assign face_s9 = mf_s9[MODE_BITS +: FACE_BITS];
   assign axis_s9 = FACE_BITS'(face_s9 / APM_FACES_PER_AXIS);
   assign g11_s9  = g_s9[GW-1:0];
   assign g22_s9  = g_s9[2*GW-1:GW];

   always_comb begin
      if (mode_s9 == MODE_AREA) begin
         xsel = DW'(det_ff >>> (2 * F));
      end else if (axis_s9 == AXIS_Y) begin
         xsel = DW'(g22_s9);
      end else begin
         xsel = DW'(g11_s9);
      end
   end

   // square root: one result bit per stage, operand limited to 2W-2 bits
   logic [2*W-3:0] sr_ff [0:W-1];
   logic [W-2:0]   sq_ff [0:W-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sr_ff[0] <= xsel[2*W-3:0];
         sq_ff[0] <= '0;
         sqsat_ff <= |xsel[DW-1:2*W-2];
         detz_ff  <= (det_ff == '0);
      end
   end

   for (genvar k = 0; k < W - 1; k++) begin : g_sqrt
      localparam int J = W - 2 - k;
      logic [2*W-2:0] trial;
      logic [2*W-2:0] diff;

      assign trial = ((2*W-1)'(sq_ff[k]) << (J + 1)) + ((2*W-1)'(1) << (2 * J));
      assign diff  = (2*W-1)'(sr_ff[k]) - trial;

      // keep the bit when the trial square still fits
      always_ff @(posedge clock) begin
         if (adv) begin
            if ((2*W-1)'(sr_ff[k]) >= trial) begin
               sr_ff[k+1] <= diff[2*W-3:0];
               sq_ff[k+1] <= sq_ff[k] | ((W-1)'(1) << J);
            end else begin
               sr_ff[k+1] <= sr_ff[k];
               sq_ff[k+1] <= sq_ff[k];
            end
         end
      end
   end

   logic [W-2:0] root_o;

   apm_dly #(.WIDTH(W-1), .DEPTH(5)) u_d_root (.clock, .adv_i(adv), .d_i(sq_ff[W-1]), .q_o(root_o));
   apm_dly #(.WIDTH(2), .DEPTH(W+4)) u_d_sqf (.clock, .adv_i(adv),
      .d_i({detz_ff, sqsat_ff}), .q_o(sqf_o));

   // ---------------- stages 10-12: numerator products ----------------
   logic signed [E-1:0]  exx_s9, exy_s9, eyx_s9, eyy_s9;
   logic signed [NW-1:0] p_n00, p_n01, p_n10, p_n11;

   assign exx_s9 = e_s9[0*E +: E];
   assign exy_s9 = e_s9[1*E +: E];
   assign eyx_s9 = e_s9[2*E +: E];
   assign eyy_s9 = e_s9[3*E +: E];

   apm_mul #(.AW(AW3), .BW(E)) u_m_n00 (.clock, .adv_i(adv), .a_i(a_ff), .b_i(exx_s9), .p_o(p_n00));
   apm_mul #(.AW(AW3), .BW(E)) u_m_n01 (.clock, .adv_i(adv), .a_i(b_ff), .b_i(eyx_s9), .p_o(p_n01));
   apm_mul #(.AW(AW3), .BW(E)) u_m_n10 (.clock, .adv_i(adv), .a_i(a_ff), .b_i(exy_s9), .p_o(p_n10));
   apm_mul #(.AW(AW3), .BW(E)) u_m_n11 (.clock, .adv_i(adv), .a_i(b_ff), .b_i(eyy_s9), .p_o(p_n11));

   logic [DW-1:0] det_s12;

   apm_dly #(.WIDTH(DW), .DEPTH(3)) u_d_det (.clock, .adv_i(adv), .d_i(det_ff), .q_o(det_s12));

   // ---------------- stage 13: numerators ----------------
   logic signed [NW-1:0] num0_ff, num1_ff;
   logic [DW-1:0]        det13_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num0_ff  <= p_n00 + p_n01;
         num1_ff  <= p_n10 + p_n11;
         det13_ff <= det_s12;
      end
   end

   // ---------------- stage 14: divider setup ----------------
   logic [NW-1:0] mag0, mag1;
   logic [RW-1:0] n0_in, n1_in, d_in;
   logic [RW-1:0] dr0_ff [0:W];
   logic [RW-1:0] dr1_ff [0:W];
   logic [RW-1:0] dd_ff  [0:W];
   logic [W-1:0]  dq0_ff [0:W];
   logic [W-1:0]  dq1_ff [0:W];
   logic [3:0]    dvf_ff, dvf_o;

   assign mag0  = num0_ff[NW-1] ? NW'(~num0_ff + 1'b1) : num0_ff;
   assign mag1  = num1_ff[NW-1] ? NW'(~num1_ff + 1'b1) : num1_ff;
   assign n0_in = (RW'(mag0) << (F + 1)) + RW'(det13_ff);
   assign n1_in = (RW'(mag1) << (F + 1)) + RW'(det13_ff);
   assign d_in  = RW'(det13_ff) << 1;

   always_ff @(posedge clock) begin
      if (adv) begin
         dr0_ff[0] <= n0_in;
         dr1_ff[0] <= n1_in;
         dd_ff[0]  <= d_in;
         dq0_ff[0] <= '0;
         dq1_ff[0] <= '0;
         dvf_ff    <= {num1_ff[NW-1], num0_ff[NW-1],
                       n1_in >= (d_in << W), n0_in >= (d_in << W)};
      end
   end

   apm_dly #(.WIDTH(4), .DEPTH(W)) u_d_dvf (.clock, .adv_i(adv), .d_i(dvf_ff), .q_o(dvf_o));

   // restoring division, one quotient bit per stage for both lanes
   for (genvar k = 0; k < W; k++) begin : g_div
      localparam int I = W - 1 - k;
      logic [RW-1:0] dsh;
      logic [RW:0]   s0, s1;

      assign dsh = dd_ff[k] << I;
      assign s0  = {1'b0, dr0_ff[k]} - {1'b0, dsh};
      assign s1  = {1'b0, dr1_ff[k]} - {1'b0, dsh};

      always_ff @(posedge clock) begin
         if (adv) begin
            dd_ff[k+1]  <= dd_ff[k];
            dr0_ff[k+1] <= s0[RW] ? dr0_ff[k] : s0[RW-1:0];
            dr1_ff[k+1] <= s1[RW] ? dr1_ff[k] : s1[RW-1:0];
            dq0_ff[k+1] <= dq0_ff[k] | (W'(!s0[RW]) << I);
            dq1_ff[k+1] <= dq1_ff[k] | (W'(!s1[RW]) << I);
         end
      end
   end

   // ---------------- final stage: select and saturate ----------------
   function automatic logic [W-1:0] div_fin(logic [W-1:0] q, logic ovf, logic neg);
      logic [W-1:0] r;
      if (ovf) begin
         r = neg ? WMIN : WMAX;
      end else if (neg) begin
         r = (q > WMIN) ? WMIN : W'(~q + 1'b1);
      end else begin
         r = q[W-1] ? WMAX : q;
      end
      return r;
   endfunction

   logic [MODE_BITS-1:0]   mode_o;
   logic [FACE_BITS-1:0]   face_o, axis_o;
   logic [W-1:0]           root_val;
   logic [W-1:0]           r0_in, r1_in, r0_ff, r1_ff;
   logic [STATUS_BITS-1:0] st_in, st_ff;

   assign mode_o   = mf_o[MODE_BITS-1:0];
   assign face_o   = mf_o[MODE_BITS +: FACE_BITS];
   assign axis_o   = FACE_BITS'(face_o / APM_FACES_PER_AXIS);
   assign root_val = sqf_o[0] ? WMAX : W'(root_o);

   always_comb begin
      r0_in = '0;
      r1_in = '0;
      st_in = ST_OK;
      case (mode_o)
         MODE_MAP: begin
            r0_in = m0_o[W-1:0];
            r1_in = m0_o[2*W-1:W];
         end
         MODE_AREA: begin
            if (sqf_o[1]) begin
               st_in = ST_DEGEN;
            end else begin
               r0_in = root_val;
            end
         end
         MODE_FACE: begin
            if (axis_o > AXIS_X) begin
               st_in = ST_FACE;
            end else begin
               r0_in = root_val;
            end
         end
         MODE_GRAD: begin
            if (sqf_o[1]) begin
               st_in = ST_DEGEN;
            end else begin
               r0_in = div_fin(dq0_ff[W], dvf_o[0], dvf_o[2]);
               r1_in = div_fin(dq1_ff[W], dvf_o[1], dvf_o[3]);
            end
         end
         default: begin
            st_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
         st_ff <= st_in;
      end
   end

   assign rsp_tvalid = vs_ff[L];
   assign rsp_tdata  = RSP_DW'({r1_ff, r0_ff});
   assign rsp_tuser  = st_ff;

   // ---------------- checks ----------------
   `APM_ASSERT_NXT(a_stall_hold, clock, reset, !adv, $stable(vs_ff), "pipeline moved while stalled")
   `APM_ASSERT_IMP(a_face_zero, clock, reset, rsp_tvalid && (rsp_tuser == ST_FACE), rsp_tdata == '0, "face error beat carries data")
   `APM_ASSERT_IMP(a_degen_zero, clock, reset, rsp_tvalid && (rsp_tuser == ST_DEGEN), rsp_tdata == '0, "degenerate beat carries data")

endmodule

// ----- verif/tb_affine_parallelogram_map_2d.sv -----
// self-checking bench for the planar parallelogram mapping block
module tb_affine_parallelogram_map_2d;
   import apm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WB     = APM_WORD_BITS;
   localparam int FB     = APM_FRAC_BITS;
   localparam int REQ_DW = ((10 * WB + FACE_BITS + 7) / 8) * 8;
   localparam int RSP_DW = ((2 * WB + 7) / 8) * 8;
   localparam int LAT    = WB + 15;
   localparam int NRAND  = 1600;
   localparam int XW     = 256;

   typedef logic signed [XW-1:0] wide_t;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [WB-1:0] c0x, c0y, c1x, c1y, c2x, c2y, rx, ry, v0, v1;
      logic [FACE_BITS-1:0] face;
   } elem_t;

   typedef struct packed {
      logic [WB-1:0] r0, r1;
      logic [STATUS_BITS-1:0] st;
   } mapped_t;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic [MODE_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0] rsp_tuser;

   elem_t   pending_q[$];
   mapped_t mapped_q[$];
   int errors = 0;
   bit hold_long = 1;

   affine_parallelogram_map_2d dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic wide_t sx(logic [WB-1:0] v);
      return wide_t'($signed(v));
   endfunction

   function automatic logic [WB-1:0] clamp(wide_t v);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (WB - 1)) - 1;
      lo = -(wide_t'(1) <<< (WB - 1));
      if (v > hi) return hi[WB-1:0];
      if (v < lo) return lo[WB-1:0];
      return v[WB-1:0];
   endfunction

   // floor sqrt of a nonnegative value, bit by bit
   function automatic wide_t isqrt(wide_t x);
      wide_t r, t;
      r = 0;
      for (int b = XW / 2 - 2; b >= 0; b--) begin
         t = r | (wide_t'(1) <<< b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   // quotient rounded to nearest, ties away from zero
   function automatic wide_t div_near(wide_t num, wide_t det);
      wide_t mag, q;
      mag = num < 0 ? -num : num;
      q = ((mag <<< (FB + 1)) + det) / (det <<< 1);
      return num < 0 ? -q : q;
   endfunction

   function automatic mapped_t map_element(elem_t e);
      mapped_t m;
      wide_t ex0, ex1, ey0, ey1, g11, g12, g22, det, a, b, half;
      ex0 = sx(e.c1x) - sx(e.c0x);
      ex1 = sx(e.c1y) - sx(e.c0y);
      ey0 = sx(e.c2x) - sx(e.c0x);
      ey1 = sx(e.c2y) - sx(e.c0y);
      g11 = ex0 * ex0 + ex1 * ex1;
      g12 = ex0 * ey0 + ex1 * ey1;
      g22 = ey0 * ey0 + ey1 * ey1;
      det = g11 * g22 - g12 * g12;
      half = wide_t'(1) <<< (FB - 1);
      m = '0;
      m.st = ST_OK;
      case (e.mode)
         MODE_MAP: begin
            m.r0 = clamp(((sx(e.c0x) <<< FB) + sx(e.rx) * ex0 + sx(e.ry) * ey0 + half) >>> FB);
            m.r1 = clamp(((sx(e.c0y) <<< FB) + sx(e.rx) * ex1 + sx(e.ry) * ey1 + half) >>> FB);
         end
         MODE_AREA: begin
            if (det == 0) m.st = ST_DEGEN;
            else m.r0 = clamp(isqrt(det >>> (2 * FB)));
         end
         MODE_FACE: begin
            if (e.face / APM_FACES_PER_AXIS == AXIS_Y) m.r0 = clamp(isqrt(g22));
            else if (e.face / APM_FACES_PER_AXIS == AXIS_X) m.r0 = clamp(isqrt(g11));
            else m.st = ST_FACE;
         end
         default: begin
            if (det == 0) m.st = ST_DEGEN;
            else begin
               a = g22 * sx(e.v0) - g12 * sx(e.v1);
               b = g11 * sx(e.v1) - g12 * sx(e.v0);
               m.r0 = clamp(div_near(a * ex0 + b * ey0, det));
               m.r1 = clamp(div_near(a * ex1 + b * ey1, det));
            end
         end
      endcase
      return m;
   endfunction

   // mostly small values, sometimes extremes or full range
   function automatic logic [WB-1:0] rnd_word();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(WB-1){1'b1}}};
         1: return {1'b1, {(WB-1){1'b0}}};
         2, 3: return $urandom;
         default: return WB'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   function automatic elem_t rnd_elem();
      elem_t e;
      e.mode = MODE_BITS'($urandom_range(0, 3));
      e.c0x = rnd_word(); e.c0y = rnd_word();
      e.c1x = rnd_word(); e.c1y = rnd_word();
      e.c2x = rnd_word(); e.c2y = rnd_word();
      e.rx = rnd_word();  e.ry = rnd_word();
      e.v0 = rnd_word();  e.v1 = rnd_word();
      e.face = FACE_BITS'($urandom_range(0, 7));
      // collinear corners now and then for degenerate elements
      if ($urandom_range(0, 9) == 0) begin
         e.c2x = e.c1x; e.c2y = e.c1y;
      end
      return e;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // sender: beat from the pending queue, random gaps between beats
   int src_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap <= src_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               elem_t e;
               e = pending_q.pop_front();
               mapped_q.push_back(map_element(e));
               req_tvalid <= 1'b1;
               req_tuser <= e.mode;
               req_tdata <= REQ_DW'({e.face, e.v1, e.v0, e.ry, e.rx,
                                     e.c2y, e.c2x, e.c1y, e.c1x, e.c0y, e.c0x});
               src_gap <= gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls; a long hold-off early on fills the pipeline
   int hold_cnt = 0, snk_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_long) begin
            rsp_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 300) hold_long <= 1'b0;
         end else if (snk_gap > 0) begin
            rsp_tready <= 1'b0;
            snk_gap <= snk_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            snk_gap <= gap_len();
         end
      end
   end

   // checker: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mapped_q.size() == 0) begin
            errors <= errors + 1;
            if (errors < 10) $display("unexpected result beat %h", rsp_tdata);
         end else begin
            mapped_t m;
            m = mapped_q.pop_front();
            if (rsp_tdata[WB-1:0] !== m.r0 || rsp_tdata[2*WB-1:WB] !== m.r1
                || rsp_tuser !== m.st) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("mismatch: exp r0=%h r1=%h st=%0d got r0=%h r1=%h st=%0d",
                           m.r0, m.r1, m.st, rsp_tdata[WB-1:0],
                           rsp_tdata[2*WB-1:WB], rsp_tuser);
            end
         end
      end
   end

   initial begin
      elem_t e;
      logic [WB-1:0] mx, mn;
      mx = {1'b0, {(WB-1){1'b1}}};
      mn = {1'b1, {(WB-1){1'b0}}};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // unit square, every mode and every face
      for (int f = 0; f < 8; f++) begin
         e = '0;
         e.c1x = 1 << FB; e.c2y = 1 << FB;
         e.rx = 1 << (FB - 1); e.ry = 3 << (FB - 2);
         e.v0 = 1 << FB; e.v1 = -(2 << FB);
         e.face = FACE_BITS'(f);
         e.mode = MODE_FACE;
         pending_q.push_back(e);
         if (f < 4) begin
            e.mode = MODE_BITS'(f);
            pending_q.push_back(e);
         end
      end
      // extreme corner values in every mode
      for (int m = 0; m < 4; m++) begin
         e = '{mode: MODE_BITS'(m), c0x: mn, c0y: mx, c1x: mx, c1y: mn, c2x: mx, c2y: mx,
               rx: mx, ry: mn, v0: mn, v1: mx, face: 3'd7};
         pending_q.push_back(e);
         e = '{mode: MODE_BITS'(m), c0x: mx, c0y: mx, c1x: mx, c1y: mx, c2x: mx, c2y: mx,
               rx: mn, ry: mn, v0: mx, v1: mx, face: 3'd2};
         pending_q.push_back(e);
      end
      // degenerate elements in area and gradient modes
      e = '0; e.c1x = 5 << FB; e.c2x = 9 << FB; e.mode = MODE_AREA;
      pending_q.push_back(e);
      e.mode = MODE_GRAD;
      pending_q.push_back(e);
      for (int i = 0; i < NRAND; i++) pending_q.push_back(rnd_elem());
      wait (pending_q.size() == 0 && mapped_q.size() == 0);
      repeat (LAT + 20) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/apm_pkg.sv
rtl/core/apm_dly.sv
rtl/core/apm_mul.sv
rtl/core/affine_parallelogram_map_2d.sv
verif/tb_affine_parallelogram_map_2d.sv
